// ===== hw/rtl/mrq_pkg.sv =====
package mrq_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

  // scheduling constants
  localparam logic [4:0]  WEIGHT_BASE   = 5'd20;
  localparam logic [4:0]  PRIO_MAX      = 5'd19;
  localparam logic [7:0]  QUANTUM_RESET = 8'd4;
  localparam logic [20:0] VRT_MAX       = 21'h1FFFFF;
  localparam logic [31:0] U32_MAX       = 32'hFFFFFFFF;

  // operation codes carried in tuser
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_SLICE = 1'b1;

  // broadcast commands to the cell row
  localparam logic [1:0] CMD_NOP = 2'd0;
  localparam logic [1:0] CMD_ADD = 2'd1;
  localparam logic [1:0] CMD_UPD = 2'd2;
  localparam logic [1:0] CMD_REM = 2'd3;

  // one queued task
  typedef struct packed {
    logic [15:0] id;
    logic [4:0]  prio;
    logic [15:0] rem;
    logic [20:0] vrt;
    logic [31:0] wait_t;
  } entry_t;

  // running minimum handed from cell to cell
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    entry_t           ent;
  } scan_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic [1:0]       cmd;
    logic [OCC_W-1:0] occ;
    logic [IDX_W-1:0] sel;
    logic [15:0]      add_id;
    logic [4:0]       add_prio;
    logic [15:0]      add_burst;
    logic [15:0]      upd_rem;
    logic [20:0]      upd_vrt;
    logic [7:0]       slice;
  } cell_ctrl_t;

  // saturating add of a slice onto a 32-bit counter
  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? U32_MAX : s[31:0];
  endfunction

endpackage

// ===== hw/rtl/mrq_cell.sv =====
module mrq_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [mrq_pkg::IDX_W-1:0]   cell_idx_i,
  input  mrq_pkg::cell_ctrl_t         ctrl_i,
  input  mrq_pkg::entry_t             right_i,
  input  mrq_pkg::scan_t              scan_i,
  output mrq_pkg::scan_t              scan_o,
  output mrq_pkg::entry_t             ent_o
);

  mrq_pkg::entry_t ent_q, ent_d;
  mrq_pkg::scan_t  scan_q, scan_d;
  logic            active;

  assign active = mrq_pkg::OCC_W'(cell_idx_i) < ctrl_i.occ;

  // keep the earlier entry on ties: replace only on strictly smaller vruntime
  always_comb begin
    scan_d = scan_i;
    if (active && (!scan_i.found || ent_q.vrt < scan_i.ent.vrt)) begin
      scan_d.found = 1'b1;
      scan_d.idx   = cell_idx_i;
      scan_d.ent   = ent_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      scan_q <= scan_d;
    end
  end

  // entry update for add, slice update and removal shift
  always_comb begin
    ent_d = ent_q;
    case (ctrl_i.cmd)
      mrq_pkg::CMD_ADD: begin
        if (mrq_pkg::OCC_W'(cell_idx_i) == ctrl_i.occ) begin
          ent_d.id     = ctrl_i.add_id;
          ent_d.prio   = ctrl_i.add_prio;
          ent_d.rem    = ctrl_i.add_burst;
          ent_d.vrt    = '0;
          ent_d.wait_t = '0;
        end
      end
      mrq_pkg::CMD_UPD: begin
        if (cell_idx_i == ctrl_i.sel) begin
          ent_d.rem = ctrl_i.upd_rem;
          ent_d.vrt = ctrl_i.upd_vrt;
        end else if (active) begin
          ent_d.wait_t = mrq_pkg::sat_add32(ent_q.wait_t, {24'd0, ctrl_i.slice});
        end
      end
      mrq_pkg::CMD_REM: begin
        if (cell_idx_i >= ctrl_i.sel) begin
          ent_d        = right_i;
          ent_d.wait_t = mrq_pkg::sat_add32(right_i.wait_t, {24'd0, ctrl_i.slice});
        end else if (active) begin
          ent_d.wait_t = mrq_pkg::sat_add32(ent_q.wait_t, {24'd0, ctrl_i.slice});
        end
      end
      default: begin
        ent_d = ent_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign scan_o = scan_q;
  assign ent_o  = ent_q;

endmodule

// ===== hw/rtl/min_vruntime_run_queue_scheduler_unit.sv =====
// Minimum-virtual-runtime run queue scheduler.
// Input stream s_axis: tuser selects the operation (0 add a task, 1 run a
// slice); tdata carries the task id, priority and burst time of an add.
// Output stream m_axis: one result transaction per input transaction.
// Config channel cfg: writes the 8-bit time quantum (reset value 4); the user must
// write it only while the block is idle, which the block itself does not enforce; cfg_ready_o is always high.
// Tasks live in a row of QUEUE_DEPTH cells. A slice sends a running minimum
// down the row, one cell per cycle, in the scan state, then passes through
// the compute and update states before its result is offered. An add or a
// slice on an empty queue goes from idle straight to offering its result.
// The length of the cell row sets the slice latency.
// One transaction is in flight at a time: s_axis_tready is high only while
// no result is pending. A stalled receiver keeps the result on m_axis and
// holds off the next input.
// Reset empties the queue and clears the global time and switch counter.
module min_vruntime_run_queue_scheduler_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // task_id[15:0], priority_req[20:16], burst_len[36:21], zero pad
  input  logic [39:0]  s_axis_tdata,
  // func
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // valid_res[0], ran_task_id[16:1], slice_length[24:17], remaining_after[40:25],
  // vruntime_after[61:41], completed[62], wait_total[94:63], turnaround[126:95],
  // queue_count[131:127], switch_count[163:132], elapsed_time[195:164], zero pad
  output logic [199:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_data_i
);

  localparam int D = mrq_pkg::QUEUE_DEPTH;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_CALC = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]                  state_q, state_d;
  logic [mrq_pkg::IDX_W-1:0]   cnt_q, cnt_d;
  logic [mrq_pkg::OCC_W-1:0]   occ_q, occ_d;
  logic [31:0]                 clock_q, clock_d;
  logic [31:0]                 switch_q, switch_d;
  logic [7:0]                  quantum_q;
  logic                        done_q, done_d;
  logic [mrq_pkg::IDX_W-1:0]   sel_q, sel_d;

  // result fields
  logic        r_valid_q, r_valid_d;
  logic [15:0] r_id_q, r_id_d;
  logic [7:0]  r_slice_q, r_slice_d;
  logic [15:0] r_rem_q, r_rem_d;
  logic [20:0] r_vrt_q, r_vrt_d;
  logic [31:0] r_wait_q, r_wait_d;
  logic [31:0] r_turn_q, r_turn_d;

  mrq_pkg::cell_ctrl_t ctrl;
  mrq_pkg::scan_t      scan_chain [D+1];
  mrq_pkg::entry_t     ents [D];

  logic        s_fire, m_fire;
  logic [4:0]  add_prio;
  logic [7:0]  c_slice;
  logic [15:0] c_rem;
  logic [12:0] c_prod;
  logic [21:0] c_vsum;
  logic [20:0] c_vrt;
  logic [31:0] c_clock;
  logic [31:0] occ_ext;
  mrq_pkg::scan_t tok;

  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign cfg_ready_o   = 1'b1;

  // quantum register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= mrq_pkg::QUANTUM_RESET;
    end else if (cfg_valid_i) begin
      quantum_q <= cfg_data_i;
    end
  end

  assign add_prio = (s_axis_tdata[20:16] > mrq_pkg::PRIO_MAX) ? mrq_pkg::PRIO_MAX
                                                              : s_axis_tdata[20:16];

  // slice arithmetic on the minimum found by the scan
  assign tok     = scan_chain[D];
  assign c_slice = (tok.ent.rem < {8'd0, quantum_q}) ? tok.ent.rem[7:0] : quantum_q;
  assign c_rem   = tok.ent.rem - {8'd0, c_slice};
  assign c_prod  = 13'(c_slice) * 13'(mrq_pkg::WEIGHT_BASE - tok.ent.prio);
  assign c_vsum  = {1'b0, tok.ent.vrt} + {9'd0, c_prod};
  assign c_vrt   = c_vsum[21] ? mrq_pkg::VRT_MAX : c_vsum[20:0];
  assign c_clock = mrq_pkg::sat_add32(clock_q, {24'd0, c_slice});

  // cell row
  assign scan_chain[0] = '0;
  for (genvar g = 0; g < D; g++) begin : g_cell
    mrq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (mrq_pkg::IDX_W'(g)),
      .ctrl_i     (ctrl),
      .right_i    (ents[(g + 1 < D) ? g + 1 : g]),
      .scan_i     (scan_chain[g]),
      .scan_o     (scan_chain[g+1]),
      .ent_o      (ents[g])
    );
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    occ_d     = occ_q;
    clock_d   = clock_q;
    switch_d  = switch_q;
    done_d    = done_q;
    sel_d     = sel_q;
    r_valid_d = r_valid_q;
    r_id_d    = r_id_q;
    r_slice_d = r_slice_q;
    r_rem_d   = r_rem_q;
    r_vrt_d   = r_vrt_q;
    r_wait_d  = r_wait_q;
    r_turn_d  = r_turn_q;

    ctrl           = '0;
    ctrl.cmd       = mrq_pkg::CMD_NOP;
    ctrl.occ       = occ_q;
    ctrl.sel       = sel_q;
    ctrl.add_id    = s_axis_tdata[15:0];
    ctrl.add_prio  = add_prio;
    ctrl.add_burst = s_axis_tdata[36:21];
    ctrl.upd_rem   = r_rem_q;
    ctrl.upd_vrt   = r_vrt_q;
    ctrl.slice     = r_slice_q;

    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          r_valid_d = 1'b0;
          r_id_d    = '0;
          r_slice_d = '0;
          r_rem_d   = '0;
          r_vrt_d   = '0;
          r_wait_d  = '0;
          r_turn_d  = '0;
          done_d    = 1'b0;
          if (s_axis_tuser == mrq_pkg::FUNC_ADD) begin
            state_d = ST_OUT;
            if (occ_q < mrq_pkg::OCC_W'(D)) begin
              ctrl.cmd  = mrq_pkg::CMD_ADD;
              occ_d     = occ_q + mrq_pkg::OCC_W'(1);
              r_valid_d = 1'b1;
            end
          end else if (occ_q == '0) begin
            state_d = ST_OUT;
          end else begin
            state_d = ST_SCAN;
            cnt_d   = '0;
          end
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + mrq_pkg::IDX_W'(1);
        if (cnt_q == mrq_pkg::IDX_W'(D - 1)) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        r_valid_d = 1'b1;
        r_id_d    = tok.ent.id;
        r_slice_d = c_slice;
        r_rem_d   = c_rem;
        r_vrt_d   = c_vrt;
        r_wait_d  = tok.ent.wait_t;
        sel_d     = tok.idx;
        clock_d   = c_clock;
        done_d    = (c_rem == '0);
        if (c_rem == '0) begin
          r_turn_d = c_clock;
          occ_d    = occ_q - mrq_pkg::OCC_W'(1);
        end else begin
          r_turn_d = '0;
          switch_d = mrq_pkg::sat_add32(switch_q, 32'd1);
        end
        state_d = ST_UPD;
      end
      ST_UPD: begin
        ctrl.cmd = done_q ? mrq_pkg::CMD_REM : mrq_pkg::CMD_UPD;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        if (m_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      occ_q    <= '0;
      clock_q  <= '0;
      switch_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      occ_q    <= occ_d;
      clock_q  <= clock_d;
      switch_q <= switch_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q     <= sel_d;
    r_valid_q <= r_valid_d;
    r_id_q    <= r_id_d;
    r_slice_q <= r_slice_d;
    r_rem_q   <= r_rem_d;
    r_vrt_q   <= r_vrt_d;
    r_wait_q  <= r_wait_d;
    r_turn_q  <= r_turn_d;
  end

  // result packing
  assign occ_ext = 32'(occ_q);
  assign m_axis_tdata = {4'd0, clock_q, switch_q, occ_ext[4:0], r_turn_q, r_wait_q, done_q,
                         r_vrt_q, r_rem_q, r_slice_q, r_id_q, r_valid_q};

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= mrq_pkg::OCC_W'(D))
    else $error("queue occupancy above depth");
  a_remove_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC && c_rem == '0) |=> (occ_q == $past(occ_q) - mrq_pkg::OCC_W'(1)))
    else $error("completed task not removed");
  a_scan_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC) |-> tok.found)
    else $error("scan ended without a candidate");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && !m_axis_tready) |=> (state_q == ST_OUT))
    else $error("result dropped while stalled");
`endif

endmodule
